// ===== sv/wrus_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrus_pkg: shared types and codes of the read-use scoreboard
// Item and result structs, operation codes, status codes, register indexes
// and default sizes.
// ----------------------------------------------------------------------------
package wrus_pkg;

    localparam int WARPS_DEF      = 64;
    localparam int REGS_DEF       = 256;
    localparam int COUNT_BITS_DEF = 4;

    // operation codes; unused codes act as query
    localparam logic [2:0] FUNC_RESERVE   = 3'd0;
    localparam logic [2:0] FUNC_RELEASE   = 3'd1;
    localparam logic [2:0] FUNC_CHECK_DST = 3'd2;
    localparam logic [2:0] FUNC_CHECK_SRC = 3'd3;
    localparam logic [2:0] FUNC_QUERY     = 3'd4;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NOT_HELD = 2'd2;

    // configuration register indexes
    localparam logic CFG_ENABLE   = 1'b0;
    localparam logic CFG_MAX_USES = 1'b1;

    typedef struct packed {
        logic [2:0] func;
        logic [5:0] warp;
        logic [7:0] register_id;
    } wrus_in_t;

    typedef struct packed {
        logic       collision;
        logic [1:0] status;
        logic [3:0] use_count;
        logic [8:0] warp_reg_count;
        logic       warp_busy;
    } wrus_out_t;

endpackage

// ===== sv/war_read_use_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// war_read_use_scoreboard: write-after-read scoreboard with use counts
// Per warp and register, a saturating count of pending source reads lives in
// a synchronous memory; a second memory holds each warp's count of registers
// with pending uses. Items read both; reserves and releases modify and write back.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_        in   s_valid / s_ready   s_data  (wrus_in_t)
//  m_        out  m_valid / m_ready   m_data  (wrus_out_t)
//  cfg_      in   cfg_we              cfg_index, cfg_wdata
//
//  One item per cycle unless the output stalls: the memory read is issued at
//  acceptance, the count is updated in the item stage and written back as the
//  item leaves it, and the result lands in the output register. A write to the
//  entry that the following item reads is forwarded, so back-to-back items to
//  one register see fresh counts. After reset a clearing pass zeroes the count
//  and pending-register memories, with s_ready low.
//  A stalled m_ready holds the result and, one item later, s_ready.
// ----------------------------------------------------------------------------
module war_read_use_scoreboard
    import wrus_pkg::*;
#(
    parameter int WARPS      = WARPS_DEF,
    parameter int REGS       = REGS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  wrus_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output wrus_out_t m_data,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [3:0] cfg_wdata
);

    localparam int WB      = (WARPS > 1) ? $clog2(WARPS) : 1;
    localparam int RB      = $clog2(REGS);
    localparam int AB      = WB + RB;
    localparam int DEPTH   = WARPS << RB;
    localparam int PB      = $clog2(REGS + 1);
    localparam int CNT_MAX = (1 << COUNT_BITS) - 1;

    // count memory and pending-register memory
    logic [COUNT_BITS-1:0] cnt_mem [DEPTH];
    logic [PB-1:0]         pend_mem [WARPS];

    // configuration
    logic       enable_reg;
    logic [3:0] max_uses_reg;

    // clearing pass
    logic          clr_active_reg;
    logic [AB-1:0] clr_addr_reg;
    logic          clr_last;

    // item stage (memory data arrives here)
    logic                  s1_valid_reg;
    wrus_in_t              s1_item_reg;
    logic                  s1_warp_ok_reg;
    logic                  s1_reg_ok_reg;
    logic [AB-1:0]         s1_addr_reg;
    logic [WB-1:0]         s1_widx_reg;
    logic [COUNT_BITS-1:0] rd_cnt_reg;
    logic [PB-1:0]         rd_pend_reg;
    logic                  fwd_cnt_hit_reg;
    logic                  fwd_pend_hit_reg;
    logic [COUNT_BITS-1:0] fwd_cnt_reg;
    logic [PB-1:0]         fwd_pend_reg;

    // output register
    logic      m_valid_reg;
    wrus_out_t m_data_reg;

    // input decode
    logic          s_accept;
    logic [8:0]    in_warp_ext;
    logic [10:0]   in_reg_ext;
    logic          in_warp_ok;
    logic          in_reg_ok;
    logic [WB-1:0] in_widx;
    logic [RB-1:0] in_ridx;
    logic [AB-1:0] in_addr;

    // item stage logic
    logic                  s1_adv;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic [PB-1:0]         cur_pend;
    logic [7:0]            lim;
    logic [7:0]            cnt_ext;
    logic [7:0]            max_ext;
    logic                  at_limit;
    logic                  item_ok;
    logic                  reg_op;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] cnt_next;
    logic [PB-1:0]         pend_next;
    wrus_out_t             res_next;

    // memory write port
    logic                  mem_we;
    logic [AB-1:0]         mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  pend_we;
    logic [WB-1:0]         pend_waddr;
    logic [PB-1:0]         pend_wdata;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !clr_active_reg && (!s1_valid_reg || s1_adv);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign in_warp_ext = {3'b000, s_data.warp};
    assign in_reg_ext  = {3'b000, s_data.register_id};
    assign in_warp_ok  = in_warp_ext < 9'(WARPS);
    assign in_reg_ok   = in_reg_ext < 11'(REGS);
    assign in_widx     = in_warp_ok ? in_warp_ext[WB-1:0] : '0;
    assign in_ridx     = in_reg_ok ? in_reg_ext[RB-1:0] : '0;
    assign in_addr     = {in_widx, in_ridx};

    assign clr_last = (clr_addr_reg == AB'(DEPTH - 1));

    // ------------------------------------------------------------------
    // count update
    // ------------------------------------------------------------------
    always_comb begin
        cur_cnt  = fwd_cnt_hit_reg ? fwd_cnt_reg : rd_cnt_reg;
        cur_pend = fwd_pend_hit_reg ? fwd_pend_reg : rd_pend_reg;
        max_ext  = {4'b0000, max_uses_reg};
        if (max_ext == 8'd0) begin
            lim = 8'd1;
        end else if (max_ext > 8'(CNT_MAX)) begin
            lim = 8'(CNT_MAX);
        end else begin
            lim = max_ext;
        end
        cnt_ext  = 8'(cur_cnt);
        at_limit = cnt_ext >= lim;
        item_ok  = enable_reg && s1_warp_ok_reg;
        reg_op   = s1_reg_ok_reg && (s1_item_reg.func <= FUNC_CHECK_SRC);

        wr_en     = 1'b0;
        cnt_next  = cur_cnt;
        pend_next = cur_pend;
        res_next  = '0;
        if (item_ok) begin
            if (reg_op) begin
                case (s1_item_reg.func)
                    FUNC_RESERVE: begin
                        if (at_limit) begin
                            res_next.status = STATUS_FULL;
                        end else begin
                            wr_en    = 1'b1;
                            cnt_next = cur_cnt + 1'b1;
                            if (cur_cnt == '0) begin
                                pend_next = cur_pend + 1'b1;
                            end
                        end
                    end
                    FUNC_RELEASE: begin
                        if (cur_cnt == '0) begin
                            res_next.status = STATUS_NOT_HELD;
                        end else begin
                            wr_en    = 1'b1;
                            cnt_next = cur_cnt - 1'b1;
                            if (cnt_next == '0) begin
                                pend_next = cur_pend - 1'b1;
                            end
                        end
                    end
                    FUNC_CHECK_DST: begin
                        res_next.collision = (cur_cnt != '0);
                    end
                    default: begin
                        res_next.collision = at_limit;
                    end
                endcase
                res_next.use_count = 4'(cnt_next);
            end
            res_next.warp_reg_count = 9'(pend_next);
            res_next.warp_busy      = (pend_next != '0);
        end
        wr_en = wr_en && s1_adv;
    end

    // write port: clearing pass has priority (no items run during it)
    always_comb begin
        if (clr_active_reg) begin
            mem_we     = 1'b1;
            mem_waddr  = clr_addr_reg;
            mem_wdata  = '0;
            pend_we    = (clr_addr_reg[RB-1:0] == '0);
            pend_waddr = clr_addr_reg[AB-1:RB];
            pend_wdata = '0;
        end else begin
            mem_we     = wr_en;
            mem_waddr  = s1_addr_reg;
            mem_wdata  = cnt_next;
            pend_we    = wr_en;
            pend_waddr = s1_widx_reg;
            pend_wdata = pend_next;
        end
    end

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cnt_mem[mem_waddr] <= mem_wdata;
        end
        if (s_accept) begin
            rd_cnt_reg <= cnt_mem[in_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_we) begin
            pend_mem[pend_waddr] <= pend_wdata;
        end
        if (s_accept) begin
            rd_pend_reg <= pend_mem[in_widx];
        end
    end

    // ------------------------------------------------------------------
    // item stage, forwarding and output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg      <= s_data;
            s1_warp_ok_reg   <= in_warp_ok;
            s1_reg_ok_reg    <= in_reg_ok;
            s1_addr_reg      <= in_addr;
            s1_widx_reg      <= in_widx;
            // a write at the read edge is missed by the memory: forward it
            fwd_cnt_hit_reg  <= wr_en && (s1_addr_reg == in_addr);
            fwd_pend_hit_reg <= wr_en && (s1_widx_reg == in_widx);
            fwd_cnt_reg      <= cnt_next;
            fwd_pend_reg     <= pend_next;
        end
        if (s1_adv) begin
            m_data_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            enable_reg     <= 1'b1;
            max_uses_reg   <= 4'd3;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_last) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ENABLE:   enable_reg   <= cfg_wdata[0];
                    CFG_MAX_USES: max_uses_reg <= cfg_wdata;
                    default:      enable_reg   <= enable_reg;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_ready)
        else $error("item accepted during clearing pass");

    a_no_item_write_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !wr_en)
        else $error("item write during clearing pass");

    a_reserve_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && s1_item_reg.func == FUNC_RESERVE) |-> (8'(cnt_next) <= lim))
        else $error("reserve raised count above limit");

    a_refusal_no_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STATUS_OK) |-> !m_data.collision)
        else $error("refused item also reports a collision");

    a_count_implies_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.warp_reg_count != 9'd0) |-> m_data.warp_busy)
        else $error("pending registers without busy flag");

endmodule
